>>> hw/rtl/wmd_pkg.sv
// Shared types and constants for the waveform min/max decimator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wmd_pkg;

    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPP_WHOLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPP_FRAC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PIXEL_COUNT = 2'd2;

    localparam logic [15:0] SPP_WHOLE_RESET   = 16'd1;
    localparam logic [15:0] SPP_FRAC_RESET    = 16'd0;
    localparam logic [12:0] PIXEL_COUNT_RESET = 13'd1024;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    // 1.0 in 16.16 fixed point
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               end_of_data;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] pixel_min;
        logic signed [15:0] pixel_max;
        logic               last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [15:0] spp_whole;
        logic [15:0] spp_frac;
        logic [12:0] pixel_count;
    } cfg_t;

endpackage : wmd_pkg

`default_nettype wire

>>> hw/rtl/wmd_cfg_regs.sv
// Configuration register file: pixel width (16.16) and pixel count.
// Depends on wmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmd_cfg_regs
    import wmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spp_whole   <= SPP_WHOLE_RESET;
            cfg_reg.spp_frac    <= SPP_FRAC_RESET;
            cfg_reg.pixel_count <= PIXEL_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDX_SPP_WHOLE:   cfg_reg.spp_whole   <= cfg_data;
                CFG_IDX_SPP_FRAC:    cfg_reg.spp_frac    <= cfg_data;
                CFG_IDX_PIXEL_COUNT: cfg_reg.pixel_count <= cfg_data[12:0];
                default:             ;  // unmapped index, write ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : wmd_cfg_regs

`default_nettype wire

>>> hw/rtl/wmd_pixel_engine.sv
// Per-sample min/max tracking, pixel width accounting and column adjustment.
// Depends on wmd_pkg. Result is combinational; caller registers it.
`timescale 1ns / 1ps
`default_nettype none

module wmd_pixel_engine
    import wmd_pkg::*;
#(
    parameter int MAX_PIXELS = 4096
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire sample_t item,
    input  wire cfg_t    cfg,
    output logic         emit,
    output pixel_t       result
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W = (CNT_W > 13) ? CNT_W : 13;
    localparam logic [CMP_W-1:0] MAX_PIX_C = CMP_W'(MAX_PIXELS);

    logic signed [15:0] running_min_reg, running_min_next;
    logic signed [15:0] running_max_reg, running_max_next;
    logic [16:0]        samples_in_pixel_reg, samples_in_pixel_next;
    logic [16:0]        pixel_target_reg, pixel_target_next;
    logic [16:0]        fraction_error_reg, fraction_error_next;
    logic signed [15:0] previous_min_reg, previous_min_next;
    logic signed [15:0] previous_max_reg, previous_max_next;
    logic [CNT_W-1:0]   pixels_emitted_reg, pixels_emitted_next;

    logic [CMP_W-1:0]   pc_ext;
    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   pe_ext;
    logic               frame_full;
    logic               pixel_start;
    logic               frac_over;
    logic [16:0]        target_new;
    logic [16:0]        target_cur;
    logic signed [15:0] base_min;
    logic signed [15:0] base_max;
    logic signed [15:0] new_min;
    logic signed [15:0] new_max;
    logic [16:0]        count_inc;
    logic signed [15:0] adj_min;
    logic signed [15:0] adj_max;
    logic               last;

    always_comb
    begin
        pc_ext     = CMP_W'(cfg.pixel_count);
        limit      = (pc_ext > MAX_PIX_C) ? MAX_PIX_C : pc_ext;
        pe_ext     = CMP_W'(pixels_emitted_reg);
        frame_full = (pe_ext >= limit);

        pixel_start = (samples_in_pixel_reg == 17'd0);
        frac_over   = (fraction_error_reg > FRAC_ONE);
        target_new  = 17'(cfg.spp_whole) + 17'(frac_over);
        if (target_new == 17'd0)
            target_new = 17'd1;
        target_cur = pixel_start ? target_new : pixel_target_reg;

        base_min = pixel_start ? SAMPLE_MAX : running_min_reg;
        base_max = pixel_start ? SAMPLE_MIN : running_max_reg;
        new_min  = (item.sample < base_min) ? item.sample : base_min;
        new_max  = (item.sample > base_max) ? item.sample : base_max;
        count_inc = samples_in_pixel_reg + 17'd1;

        // Pull the column toward the previous one so drawn columns touch.
        adj_min = new_min;
        adj_max = new_max;
        if (pixels_emitted_reg != '0)
        begin
            if (new_min > previous_max_reg)
                adj_min = previous_max_reg + 16'sd1;
            if (new_max < previous_min_reg)
                adj_max = previous_min_reg - 16'sd1;
        end
        last = item.end_of_data || ((pe_ext + CMP_W'(1)) >= limit);

        emit = !frame_full && ((count_inc >= target_cur) || item.end_of_data);
        result.pixel_min  = adj_min;
        result.pixel_max  = adj_max;
        result.last_pixel = last;

        running_min_next      = running_min_reg;
        running_max_next      = running_max_reg;
        samples_in_pixel_next = samples_in_pixel_reg;
        pixel_target_next     = pixel_target_reg;
        fraction_error_next   = fraction_error_reg;
        previous_min_next     = previous_min_reg;
        previous_max_next     = previous_max_reg;
        pixels_emitted_next   = pixels_emitted_reg;

        if (!frame_full)
        begin
            if (pixel_start)
            begin
                pixel_target_next   = target_new;
                fraction_error_next = (frac_over ? (fraction_error_reg - FRAC_ONE)
                                                 : fraction_error_reg)
                                      + 17'(cfg.spp_frac);
            end
            if (emit)
            begin
                previous_min_next     = adj_min;
                previous_max_next     = adj_max;
                pixels_emitted_next   = pixels_emitted_reg + CNT_W'(1);
                samples_in_pixel_next = 17'd0;
                running_min_next      = SAMPLE_MAX;
                running_max_next      = SAMPLE_MIN;
            end
            else
            begin
                samples_in_pixel_next = count_inc;
                running_min_next      = new_min;
                running_max_next      = new_max;
            end
        end

        // End of data restarts the frame, full or not.
        if (item.end_of_data)
        begin
            running_min_next      = SAMPLE_MAX;
            running_max_next      = SAMPLE_MIN;
            samples_in_pixel_next = 17'd0;
            pixel_target_next     = 17'd0;
            fraction_error_next   = 17'd0;
            previous_min_next     = 16'sd0;
            previous_max_next     = 16'sd0;
            pixels_emitted_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_min_reg      <= SAMPLE_MAX;
            running_max_reg      <= SAMPLE_MIN;
            samples_in_pixel_reg <= 17'd0;
            pixel_target_reg     <= 17'd0;
            fraction_error_reg   <= 17'd0;
            previous_min_reg     <= 16'sd0;
            previous_max_reg     <= 16'sd0;
            pixels_emitted_reg   <= '0;
        end
        else if (step)
        begin
            running_min_reg      <= running_min_next;
            running_max_reg      <= running_max_next;
            samples_in_pixel_reg <= samples_in_pixel_next;
            pixel_target_reg     <= pixel_target_next;
            fraction_error_reg   <= fraction_error_next;
            previous_min_reg     <= previous_min_next;
            previous_max_reg     <= previous_max_next;
            pixels_emitted_reg   <= pixels_emitted_next;
        end
    end

endmodule : wmd_pixel_engine

`default_nettype wire

>>> hw/rtl/waveform_minmax_decimator_top.sv
// Waveform min/max decimator, top level. Uses wmd_pkg, wmd_cfg_regs, wmd_pixel_engine.
// An accepted sample shows its pixel (if any) on out_* via input reg, engine, result reg.
// Throughput: one sample per cycle, set by the compare/update in the engine;
// input stalls only while a pixel sits in the result register with out_ready low.
// Reset (rst_n low, async): registers to 1 / 0 / 1024, frame state cleared, both
// pipeline stages empty. No clearing pass; ready comes up on the first cycle.
`timescale 1ns / 1ps
`default_nettype none

module waveform_minmax_decimator_top
    import wmd_pkg::*;
#(
    parameter int MAX_PIXELS = 4096
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // sample stream
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire sample_t              in_data,

    // pixel stream
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pixel_t                    out_data,

    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    // Register writes must arrive only while idle; not enforced here. All are taken.
    cfg_t cfg;

    assign cfg_ready = 1'b1;

    wmd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline: input register -> engine (comb) -> result register.
    // The result register is a plain valid/data slot. The staged sample moves
    // through the engine only when that slot is empty or being drained this
    // cycle, whether or not it closes a pixel, so a pixel the receiver has not
    // taken holds the input back for as long as out_ready stays low.
    logic    s1_valid_reg;
    sample_t s1_data_reg;
    logic    out_valid_reg;
    pixel_t  out_data_reg;

    logic    out_free;
    logic    s1_advance;
    logic    eng_emit;
    pixel_t  eng_result;

    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
    end

    // State updates only on the cycle the staged sample moves on.
    wmd_pixel_engine #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_advance),
        .item   (s1_data_reg),
        .cfg    (cfg),
        .emit   (eng_emit),
        .result (eng_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_advance && eng_emit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && eng_emit)
            out_data_reg <= eng_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : waveform_minmax_decimator_top

`default_nettype wire
